FILE: hw/rtl/aff2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aff2d_pkg: shared types, formats and the sine table
// Fixed-point formats, op codes and the quarter-wave sine table of the
// 2D homogeneous affine point transform.
// ----------------------------------------------------------------------------
package aff2d_pkg;

  // Coordinate width and fraction bits (signed Q16.16)
  localparam int COORD_W        = 32;
  localparam int FRAC_BITS      = 16;
  // Sine and cosine fraction bits (1.0 is 1 << TRIG_FRAC_BITS)
  localparam int TRIG_FRAC_BITS = 15;
  // Signed trig value: sign, integer bit, fraction
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
  localparam int ANGLE_W        = 9;
  // Quarter-wave table index (0..90 degrees)
  localparam int TAB_IDX_W      = 7;
  localparam int TAB_LAST       = 90;

  // Stream payload widths
  localparam int IN_FIELDS_W    = 9 * COORD_W + ANGLE_W;
  localparam int IN_TDATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_TUSER_W     = 2;
  localparam int OUT_TDATA_W    = 3 * COORD_W;
  localparam int OUT_TUSER_W    = 1;

  typedef enum logic [1:0] {
    OP_TRANSLATE = 2'd0,
    OP_SCALE     = 2'd1,
    OP_ROTATE    = 2'd2,
    OP_PASS      = 2'd3
  } op_t;

  // Saturated coordinate with its clip flag
  typedef struct packed {
    logic                 clip;
    logic [COORD_W-1:0]   val;
  } sat_t;

  typedef logic [TRIG_FRAC_BITS:0] trig_mag_t;
  typedef trig_mag_t [TAB_LAST:0] sin_tab_t;

  // pi as Q30, Q30 one, and the Horner denominators in Q30
  localparam logic [63:0] HALF_TURN_Q30 = 64'd3373259426;
  localparam logic [63:0] Q30_ONE       = 64'd1 << 30;
  localparam logic [63:0] DEN_Q30 [7] = '{
    64'd210 << 30, 64'd156 << 30, 64'd110 << 30, 64'd72 << 30,
    64'd42 << 30,  64'd20 << 30,  64'd6 << 30
  };

  // Taylor series of sin(k deg) in Q30, Horner form with rounded steps,
  // then rounded to TRIG_FRAC_BITS. Evaluated at elaboration only.
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t    tab;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] t;
    logic [63:0] p;
    logic [63:0] s;
    for (int k = 0; k <= TAB_LAST; k++) begin
      a  = (64'(k) * HALF_TURN_Q30 + 64'd90) / 180;
      a2 = (a * a + (Q30_ONE >> 1)) >> 30;
      t  = Q30_ONE;
      for (int i = 0; i < 7; i++) begin
        p = (a2 * t + (DEN_Q30[i] >> 1)) / DEN_Q30[i];
        t = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
      end
      s = (a * t + (Q30_ONE >> 1)) >> 30;
      s = (s + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
      tab[k] = s[TRIG_FRAC_BITS:0];
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage
`default_nettype wire

FILE: hw/rtl/affine_transform_2d.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// affine_transform_2d: homogeneous 2D point transform
// Translate, scale or rotate-about-pivot of one (x, y, w) point per request,
// signed fixed point with rounding and saturation; the pass op returns the point.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tuser: op; tdata: point and operands
//  out_    | out | out_tvalid/out_tready| tuser: saturated; tdata: x, y, w
//
// One request per cycle sustained while out_tready is high; the pipeline
// stages are operand multiply, round, offset and trig lookup, trig multiply,
// trig round, and pivot restore with the output register as the last stage.
// Reset clears the stage valid bits only. A stalled output holds its result;
// each stage keeps accepting while it or a stage downstream has a free slot.
// ----------------------------------------------------------------------------
module affine_transform_2d (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // op[1:0]
  input  wire  [aff2d_pkg::IN_TUSER_W-1:0]     in_tuser,
  // x, y, w, shift_x, shift_y, factor_x, factor_y, angle_deg, pivot_x,
  // pivot_y, zero pad
  input  wire  [aff2d_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // saturated
  output logic [aff2d_pkg::OUT_TUSER_W-1:0]    out_tuser,
  // out_x, out_y, out_w
  output logic [aff2d_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int CW     = aff2d_pkg::COORD_W;
  localparam int FB     = aff2d_pkg::FRAC_BITS;
  localparam int TB     = aff2d_pkg::TRIG_FRAC_BITS;
  localparam int TW     = aff2d_pkg::TRIG_W;
  localparam int IW     = aff2d_pkg::TAB_IDX_W;
  localparam int AW     = aff2d_pkg::ANGLE_W;
  // full product, product rounded by FB, trig product and its sum
  localparam int PRW    = 2 * CW;
  localparam int PW     = PRW + 1 - FB;
  localparam int MW     = CW + TW;
  localparam int RW     = MW + 1;
  localparam int WIDE   = PRW + 2;
  localparam int STAGES = 5;

  localparam logic signed [PRW:0]  HALF_F = (PRW + 1)'(1) << (FB - 1);
  localparam logic signed [RW-1:0] HALF_T = RW'(1) << (TB - 1);
  localparam logic [AW-1:0] DEG_90  = AW'(90);
  localparam logic [AW-1:0] DEG_180 = AW'(180);
  localparam logic [AW-1:0] DEG_270 = AW'(270);
  localparam logic [AW-1:0] DEG_360 = AW'(360);

  // clip a wide signed value to the coordinate range
  function automatic aff2d_pkg::sat_t sat32(input logic signed [WIDE-1:0] v);
    aff2d_pkg::sat_t r;
    logic [WIDE-CW:0] hi;
    hi     = v[WIDE-1:CW-1];
    r.clip = !((&hi) || (~|hi));
    if (r.clip) begin
      r.val = v[WIDE-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      r.val = v[CW-1:0];
    end
    return r;
  endfunction

  // fold an angle in 0..359 into table index and sign
  function automatic logic [IW:0] quadrant(input logic [AW-1:0] a);
    logic [AW-1:0] idx;
    logic          neg;
    if (a < DEG_90) begin
      idx = a;
      neg = 1'b0;
    end else if (a < DEG_180) begin
      idx = DEG_180 - a;
      neg = 1'b0;
    end else if (a < DEG_270) begin
      idx = a - DEG_180;
      neg = 1'b1;
    end else begin
      idx = DEG_360 - a;
      neg = 1'b1;
    end
    return {neg, idx[IW-1:0]};
  endfunction

  // ---------------- input fields ----------------
  aff2d_pkg::op_t         in_op;
  logic signed [CW-1:0]   in_x, in_y, in_w;
  logic signed [CW-1:0]   in_shift_x, in_shift_y, in_factor_x, in_factor_y;
  logic signed [CW-1:0]   in_pivot_x, in_pivot_y;
  logic [AW-1:0]          in_angle;

  assign in_op       = aff2d_pkg::op_t'(in_tuser[1:0]);
  assign in_x        = in_tdata[0*CW +: CW];
  assign in_y        = in_tdata[1*CW +: CW];
  assign in_w        = in_tdata[2*CW +: CW];
  assign in_shift_x  = in_tdata[3*CW +: CW];
  assign in_shift_y  = in_tdata[4*CW +: CW];
  assign in_factor_x = in_tdata[5*CW +: CW];
  assign in_factor_y = in_tdata[6*CW +: CW];
  assign in_angle    = in_tdata[7*CW +: AW];
  assign in_pivot_x  = in_tdata[7*CW+AW +: CW];
  assign in_pivot_y  = in_tdata[8*CW+AW +: CW];

  // ---------------- stage handshake ----------------
  logic [STAGES:1] v_r;
  logic [STAGES+1:1] en;

  always_comb begin
    en[STAGES+1] = out_tready;
    for (int k = STAGES; k >= 1; k--) begin
      en[k] = ~v_r[k] | en[k+1];
    end
  end

  assign in_tready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_tvalid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // ---------------- stage 1: operand multiply, angle fold ----------------
  logic signed [CW-1:0]  mul_ax, mul_bx, mul_ay, mul_by;
  logic [AW-1:0]         ang_d, ang_c;
  logic [IW:0]           sq_nxt, cq_nxt;

  always_comb begin
    case (in_op)
      aff2d_pkg::OP_TRANSLATE: begin
        mul_ax = in_shift_x;
        mul_bx = in_w;
        mul_ay = in_shift_y;
        mul_by = in_w;
      end
      aff2d_pkg::OP_SCALE: begin
        mul_ax = in_x;
        mul_bx = in_factor_x;
        mul_ay = in_y;
        mul_by = in_factor_y;
      end
      default: begin
        mul_ax = in_pivot_x;
        mul_bx = in_w;
        mul_ay = in_pivot_y;
        mul_by = in_w;
      end
    endcase
    ang_d  = (in_angle >= DEG_360) ? in_angle - DEG_360 : in_angle;
    ang_c  = (ang_d >= DEG_270) ? ang_d - DEG_270 : ang_d + DEG_90;
    sq_nxt = quadrant(ang_d);
    cq_nxt = quadrant(ang_c);
  end

  aff2d_pkg::op_t         s1_op_r;
  logic signed [CW-1:0]   s1_x_r, s1_y_r, s1_w_r;
  logic signed [PRW-1:0]  s1_prx_r, s1_pry_r;
  logic [IW:0]            s1_sq_r, s1_cq_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_op_r  <= in_op;
      s1_x_r   <= in_x;
      s1_y_r   <= in_y;
      s1_w_r   <= in_w;
      s1_prx_r <= mul_ax * mul_bx;
      s1_pry_r <= mul_ay * mul_by;
      s1_sq_r  <= sq_nxt;
      s1_cq_r  <= cq_nxt;
    end
  end

  // ---------------- stage 2: round, offset, trig lookup ----------------
  logic signed [PRW:0]   rnd_x_sum, rnd_y_sum;
  logic signed [PW-1:0]  rnd_x, rnd_y;
  aff2d_pkg::sat_t       s2_ax_nxt, s2_ay_nxt;
  logic signed [TW-1:0]  sin_nxt, cos_nxt;

  always_comb begin
    rnd_x_sum = $signed({s1_prx_r[PRW-1], s1_prx_r}) + HALF_F;
    rnd_y_sum = $signed({s1_pry_r[PRW-1], s1_pry_r}) + HALF_F;
    rnd_x     = rnd_x_sum[PRW:FB];
    rnd_y     = rnd_y_sum[PRW:FB];
    case (s1_op_r)
      aff2d_pkg::OP_TRANSLATE: begin
        s2_ax_nxt = sat32(WIDE'(s1_x_r) + WIDE'(rnd_x));
        s2_ay_nxt = sat32(WIDE'(s1_y_r) + WIDE'(rnd_y));
      end
      aff2d_pkg::OP_SCALE: begin
        s2_ax_nxt = sat32(WIDE'(rnd_x));
        s2_ay_nxt = sat32(WIDE'(rnd_y));
      end
      aff2d_pkg::OP_ROTATE: begin
        // move the pivot to the origin
        s2_ax_nxt = sat32(WIDE'(s1_x_r) - WIDE'(rnd_x));
        s2_ay_nxt = sat32(WIDE'(s1_y_r) - WIDE'(rnd_y));
      end
      default: begin
        s2_ax_nxt = '{clip: 1'b0, val: s1_x_r};
        s2_ay_nxt = '{clip: 1'b0, val: s1_y_r};
      end
    endcase
    sin_nxt = $signed({1'b0, aff2d_pkg::SIN_TAB[s1_sq_r[IW-1:0]]});
    cos_nxt = $signed({1'b0, aff2d_pkg::SIN_TAB[s1_cq_r[IW-1:0]]});
    if (s1_sq_r[IW]) begin
      sin_nxt = -sin_nxt;
    end
    if (s1_cq_r[IW]) begin
      cos_nxt = -cos_nxt;
    end
  end

  aff2d_pkg::op_t         s2_op_r;
  logic signed [CW-1:0]   s2_w_r, s2_ax_r, s2_ay_r;
  logic signed [PW-1:0]   s2_pvx_r, s2_pvy_r;
  logic                   s2_clip_r;
  logic signed [TW-1:0]   s2_sin_r, s2_cos_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_op_r   <= s1_op_r;
      s2_w_r    <= s1_w_r;
      s2_ax_r   <= s2_ax_nxt.val;
      s2_ay_r   <= s2_ay_nxt.val;
      s2_pvx_r  <= rnd_x;
      s2_pvy_r  <= rnd_y;
      s2_clip_r <= s2_ax_nxt.clip | s2_ay_nxt.clip;
      s2_sin_r  <= sin_nxt;
      s2_cos_r  <= cos_nxt;
    end
  end

  // ---------------- stage 3: rotation products ----------------
  aff2d_pkg::op_t         s3_op_r;
  logic signed [CW-1:0]   s3_w_r, s3_ax_r, s3_ay_r;
  logic signed [PW-1:0]   s3_pvx_r, s3_pvy_r;
  logic                   s3_clip_r;
  logic signed [MW-1:0]   s3_cx_r, s3_sy_r, s3_sx_r, s3_cy_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_op_r   <= s2_op_r;
      s3_w_r    <= s2_w_r;
      s3_ax_r   <= s2_ax_r;
      s3_ay_r   <= s2_ay_r;
      s3_pvx_r  <= s2_pvx_r;
      s3_pvy_r  <= s2_pvy_r;
      s3_clip_r <= s2_clip_r;
      s3_cx_r   <= s2_cos_r * s2_ax_r;
      s3_sy_r   <= s2_sin_r * s2_ay_r;
      s3_sx_r   <= s2_sin_r * s2_ax_r;
      s3_cy_r   <= s2_cos_r * s2_ay_r;
    end
  end

  // ---------------- stage 4: rotation sums, round, clip ----------------
  logic signed [RW-1:0]   rot_x_sum, rot_y_sum;
  logic signed [RW-TB-1:0] rot_x, rot_y;
  aff2d_pkg::sat_t        s4_ux_nxt, s4_uy_nxt;

  always_comb begin
    rot_x_sum = RW'(s3_cx_r) - RW'(s3_sy_r) + HALF_T;
    rot_y_sum = RW'(s3_sx_r) + RW'(s3_cy_r) + HALF_T;
    rot_x     = rot_x_sum[RW-1:TB];
    rot_y     = rot_y_sum[RW-1:TB];
    s4_ux_nxt = sat32(WIDE'(rot_x));
    s4_uy_nxt = sat32(WIDE'(rot_y));
  end

  aff2d_pkg::op_t         s4_op_r;
  logic signed [CW-1:0]   s4_w_r, s4_ax_r, s4_ay_r, s4_ux_r, s4_uy_r;
  logic signed [PW-1:0]   s4_pvx_r, s4_pvy_r;
  logic                   s4_clip_r, s4_uclip_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_op_r    <= s3_op_r;
      s4_w_r     <= s3_w_r;
      s4_ax_r    <= s3_ax_r;
      s4_ay_r    <= s3_ay_r;
      s4_pvx_r   <= s3_pvx_r;
      s4_pvy_r   <= s3_pvy_r;
      s4_clip_r  <= s3_clip_r;
      s4_ux_r    <= s4_ux_nxt.val;
      s4_uy_r    <= s4_uy_nxt.val;
      s4_uclip_r <= s4_ux_nxt.clip | s4_uy_nxt.clip;
    end
  end

  // ---------------- stage 5: pivot restore, output register ----------------
  aff2d_pkg::sat_t        fin_x, fin_y;
  logic                   fin_clip;

  always_comb begin
    case (s4_op_r)
      aff2d_pkg::OP_ROTATE: begin
        fin_x    = sat32(WIDE'(s4_ux_r) + WIDE'(s4_pvx_r));
        fin_y    = sat32(WIDE'(s4_uy_r) + WIDE'(s4_pvy_r));
        fin_clip = s4_clip_r | s4_uclip_r | fin_x.clip | fin_y.clip;
      end
      default: begin
        fin_x    = '{clip: 1'b0, val: s4_ax_r};
        fin_y    = '{clip: 1'b0, val: s4_ay_r};
        fin_clip = s4_clip_r;
      end
    endcase
  end

  logic [CW-1:0] out_x_r, out_y_r, out_w_r;
  logic          out_sat_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      out_x_r   <= fin_x.val;
      out_y_r   <= fin_y.val;
      out_w_r   <= s4_w_r;
      out_sat_r <= fin_clip;
    end
  end

  assign out_tvalid = v_r[STAGES];
  assign out_tuser  = out_sat_r;
  assign out_tdata  = {out_w_r, out_y_r, out_x_r};

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for affine_transform_2d
// Streams translate, scale, rotate and pass-through requests into the block
// and checks every result against a fixed-point point transform computed
// here, across phases of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb;

  typedef logic signed [aff2d_pkg::COORD_W-1:0] q_t;

  // One point request as the stimulus sees it
  typedef struct {
    aff2d_pkg::op_t op;
    q_t           x;
    q_t           y;
    q_t           w;
    q_t           shift_x;
    q_t           shift_y;
    q_t           factor_x;
    q_t           factor_y;
    logic [8:0]   angle;
    q_t           pivot_x;
    q_t           pivot_y;
  } point_req_t;

  // One transformed point
  typedef struct {
    logic [31:0]  x;
    logic [31:0]  y;
    logic [31:0]  w;
    logic         sat;
  } point_res_t;

  localparam q_t     Q_ONE = 32'sh0001_0000;
  localparam q_t     Q_MAX = 32'sh7fff_ffff;
  localparam q_t     Q_MIN = 32'sh8000_0000;
  localparam longint L_MAX = 64'sh0000_0000_7fff_ffff;
  localparam longint L_MIN = -64'sh0000_0000_8000_0000;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_tvalid = 1'b0;
  logic                               in_tready;
  logic [aff2d_pkg::IN_TUSER_W-1:0]   in_tuser = '0;
  logic [aff2d_pkg::IN_TDATA_W-1:0]   in_tdata = '0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [aff2d_pkg::OUT_TUSER_W-1:0]  out_tuser;
  logic [aff2d_pkg::OUT_TDATA_W-1:0]  out_tdata;

  point_req_t  pending[$];
  point_res_t  exp_points[$];
  point_req_t  drv_req;
  point_res_t  mon_exp;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          err_cnt = 0;
  // rotation angles on and between quadrant boundaries and past a full turn
  logic [8:0]  rot_angles [8] = '{9'd0, 9'd45, 9'd90, 9'd180, 9'd270, 9'd359,
                                  9'd360, 9'd511};

  affine_transform_2d u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  // Clock and reset
  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Point transform predictor
  // ---------------------------------------------------------------------------

  // Rounded shift: add half an LSB, then floor
  function automatic longint round_shr(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  // Clip to signed 32 bits, accumulate the clip flag
  function automatic longint clip32(longint v, inout bit c);
    if (v > L_MAX) begin
      c = 1'b1;
      return L_MAX;
    end
    if (v < L_MIN) begin
      c = 1'b1;
      return L_MIN;
    end
    return v;
  endfunction

  // sin(k deg), k in 0..90: Q30 Horner Taylor series, rounded to trig bits
  function automatic longint sine_quarter(int unsigned k);
    logic [63:0] dens [7] = '{64'd210, 64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    logic [63:0] one_q30;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] t;
    logic [63:0] p;
    logic [63:0] d;
    logic [63:0] s;
    one_q30 = 64'd1 << 30;
    a  = (64'(k) * 64'd3373259426 + 64'd90) / 64'd180;
    a2 = (a * a + (one_q30 >> 1)) >> 30;
    t  = one_q30;
    for (int i = 0; i < 7; i++) begin
      d = dens[i] << 30;
      p = (a2 * t + (d >> 1)) / d;
      t = (p >= one_q30) ? 64'd0 : one_q30 - p;
    end
    s = (a * t + (one_q30 >> 1)) >> 30;
    s = (s + (64'd1 << (29 - aff2d_pkg::TRIG_FRAC_BITS))) >>
        (30 - aff2d_pkg::TRIG_FRAC_BITS);
    return longint'(s);
  endfunction

  // Full-circle sine by quadrant symmetry
  function automatic longint sine_deg(int unsigned d);
    int unsigned q;
    int unsigned r;
    d = d % 360;
    q = d / 90;
    r = d % 90;
    case (q)
      0:       return sine_quarter(r);
      1:       return sine_quarter(90 - r);
      2:       return -sine_quarter(r);
      default: return -sine_quarter(90 - r);
    endcase
  endfunction

  function automatic point_res_t transform_point(point_req_t r);
    point_res_t   o;
    longint       x;
    longint       y;
    longint       w;
    longint       rx;
    longint       ry;
    longint       px;
    longint       py;
    longint       tx;
    longint       ty;
    longint       ux;
    longint       uy;
    longint       sn;
    longint       cs;
    int unsigned  deg;
    bit           c;
    x  = longint'(r.x);
    y  = longint'(r.y);
    w  = longint'(r.w);
    rx = x;
    ry = y;
    c  = 1'b0;
    case (r.op)
      aff2d_pkg::OP_TRANSLATE: begin
        rx = clip32(x + round_shr(longint'(r.shift_x) * w, aff2d_pkg::FRAC_BITS), c);
        ry = clip32(y + round_shr(longint'(r.shift_y) * w, aff2d_pkg::FRAC_BITS), c);
      end
      aff2d_pkg::OP_SCALE: begin
        rx = clip32(round_shr(x * longint'(r.factor_x), aff2d_pkg::FRAC_BITS), c);
        ry = clip32(round_shr(y * longint'(r.factor_y), aff2d_pkg::FRAC_BITS), c);
      end
      aff2d_pkg::OP_ROTATE: begin
        deg = r.angle % 360;
        sn  = sine_deg(deg);
        cs  = sine_deg(deg + 90);
        px  = round_shr(longint'(r.pivot_x) * w, aff2d_pkg::FRAC_BITS);
        py  = round_shr(longint'(r.pivot_y) * w, aff2d_pkg::FRAC_BITS);
        tx  = clip32(x - px, c);
        ty  = clip32(y - py, c);
        ux  = clip32(round_shr(cs * tx - sn * ty, aff2d_pkg::TRIG_FRAC_BITS), c);
        uy  = clip32(round_shr(sn * tx + cs * ty, aff2d_pkg::TRIG_FRAC_BITS), c);
        rx  = clip32(ux + px, c);
        ry  = clip32(uy + py, c);
      end
      default: ;
    endcase
    o.x   = rx[31:0];
    o.y   = ry[31:0];
    o.w   = r.w;
    o.sat = c;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------------

  function automatic logic [aff2d_pkg::IN_TDATA_W-1:0] pack_req(point_req_t r);
    logic [aff2d_pkg::IN_TDATA_W-1:0] d;
    d = '0;
    d[aff2d_pkg::IN_FIELDS_W-1:0] = {r.pivot_y, r.pivot_x, r.angle, r.factor_y,
                                     r.factor_x, r.shift_y, r.shift_x, r.w, r.y, r.x};
    return d;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        exp_points.push_back(transform_point(drv_req));
      if (!in_tvalid || in_tready) begin
        if (pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          drv_req = pending.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= drv_req.op;
          in_tdata  <= pack_req(drv_req);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor and checker
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, act);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
      if (out_tvalid && out_tready) begin
        if (exp_points.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h sat %b",
                   $time, out_tdata, out_tuser);
          err_cnt++;
        end else begin
          mon_exp = exp_points.pop_front();
          check_field("out_x", mon_exp.x, out_tdata[31:0]);
          check_field("out_y", mon_exp.y, out_tdata[63:32]);
          check_field("out_w", mon_exp.w, out_tdata[95:64]);
          check_field("saturated", 32'(mon_exp.sat), 32'(out_tuser[0]));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic add_req(aff2d_pkg::op_t op, q_t x, q_t y, q_t w, q_t sx, q_t sy,
                         q_t fx, q_t fy, logic [8:0] ang, q_t px, q_t py);
    point_req_t r;
    r = '{op, x, y, w, sx, sy, fx, fy, ang, px, py};
    pending.push_back(r);
  endtask

  // Coordinate mix: extremes, small values near the origin, full range
  function automatic q_t rand_coord();
    case ($urandom_range(0, 7))
      0:       return ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
      1, 2, 3: return q_t'($urandom_range(0, 32'h000f_ffff)) - q_t'(32'h0008_0000);
      default: return q_t'($urandom);
    endcase
  endfunction

  // Factors and weights mostly small (within +/-4.0) so most results stay in range
  function automatic q_t rand_factor();
    case ($urandom_range(0, 7))
      0:       return Q_ONE;
      1:       return ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
      2:       return q_t'($urandom);
      default: return q_t'($urandom_range(0, 32'h0008_0000)) - q_t'(32'h0004_0000);
    endcase
  endfunction

  function automatic point_req_t rand_req();
    point_req_t r;
    int         sel;
    sel = $urandom_range(0, 15);
    if (sel < 5)       r.op = aff2d_pkg::OP_TRANSLATE;
    else if (sel < 10) r.op = aff2d_pkg::OP_SCALE;
    else if (sel < 15) r.op = aff2d_pkg::OP_ROTATE;
    else               r.op = aff2d_pkg::OP_PASS;
    r.x        = rand_coord();
    r.y        = rand_coord();
    r.w        = rand_factor();
    r.shift_x  = rand_coord();
    r.shift_y  = rand_coord();
    r.factor_x = rand_factor();
    r.factor_y = rand_factor();
    r.angle    = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(360, 511))
                                             : 9'($urandom_range(0, 359));
    r.pivot_x  = rand_coord();
    r.pivot_y  = rand_coord();
    return r;
  endfunction

  task automatic wait_sent();
    while (pending.size() != 0 || in_tvalid) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending.size() != 0 || in_tvalid || exp_points.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(int n, int idle, int stall);
    @(negedge clk);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) pending.push_back(rand_req());
    wait_sent();
  endtask

  initial begin
    @(posedge rst_n);
    @(negedge clk);

    // Directed: translate
    add_req(aff2d_pkg::OP_TRANSLATE, 32'sh0001_8000, -32'sh0002_4000, Q_ONE,
            32'sh0002_0000, -32'sh0000_8000, $urandom, $urandom, 9'($urandom),
            $urandom, $urandom);
    add_req(aff2d_pkg::OP_TRANSLATE, Q_MAX, Q_MIN, Q_ONE, Q_ONE, -Q_ONE,
            $urandom, $urandom, 9'($urandom), $urandom, $urandom);
    add_req(aff2d_pkg::OP_TRANSLATE, 0, 0, Q_MAX, Q_MAX, Q_MIN,
            $urandom, $urandom, 9'($urandom), $urandom, $urandom);
    add_req(aff2d_pkg::OP_TRANSLATE, 0, 0, Q_MIN, Q_MIN, 32'sd1,
            $urandom, $urandom, 9'($urandom), $urandom, $urandom);
    // half-LSB rounding, both signs
    add_req(aff2d_pkg::OP_TRANSLATE, 0, 0, 32'sd1, 32'sh0000_8000, -32'sh0000_8000,
            $urandom, $urandom, 9'($urandom), $urandom, $urandom);

    // Directed: scale
    add_req(aff2d_pkg::OP_SCALE, 32'sh0003_0000, -32'sh0007_8000, $urandom, $urandom,
            $urandom, Q_ONE, -32'sh0002_0000, 9'($urandom), $urandom, $urandom);
    add_req(aff2d_pkg::OP_SCALE, Q_MIN, Q_MAX, $urandom, $urandom, $urandom,
            Q_MIN, Q_MAX, 9'($urandom), $urandom, $urandom);
    add_req(aff2d_pkg::OP_SCALE, Q_MIN, Q_MAX, $urandom, $urandom, $urandom,
            -Q_ONE, Q_ONE, 9'($urandom), $urandom, $urandom);
    add_req(aff2d_pkg::OP_SCALE, 32'sd1, -32'sd1, $urandom, $urandom, $urandom,
            32'sh0000_8000, 32'sh0000_8000, 9'($urandom), $urandom, $urandom);

    // Directed: rotate about a pivot, quadrant boundaries and wrapped angles
    foreach (rot_angles[i]) begin
      add_req(aff2d_pkg::OP_ROTATE, 32'sh0003_0000, Q_ONE, Q_ONE, $urandom, $urandom,
              $urandom, $urandom, rot_angles[i], Q_ONE, -32'sh0002_0000);
    end
    // offset stage clips
    add_req(aff2d_pkg::OP_ROTATE, Q_MAX, Q_MIN, Q_ONE, $urandom, $urandom, $urandom,
            $urandom, 9'd30, Q_MIN, Q_MAX);
    // rotation stage clips
    add_req(aff2d_pkg::OP_ROTATE, Q_MAX, Q_MAX, Q_ONE, $urandom, $urandom, $urandom,
            $urandom, 9'd45, 0, 0);
    // zero weight: pivot vanishes
    add_req(aff2d_pkg::OP_ROTATE, 32'sh0001_0000, 32'sh0002_0000, 0, $urandom, $urandom,
            $urandom, $urandom, 9'd120, Q_MAX, Q_MIN);
    // huge pivot offset
    add_req(aff2d_pkg::OP_ROTATE, Q_MIN, Q_MAX, Q_MIN, $urandom, $urandom, $urandom,
            $urandom, 9'd200, Q_MIN, Q_MAX);

    // Directed: unused op code passes the point through
    add_req(aff2d_pkg::OP_PASS, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, 9'($urandom), $urandom, $urandom);
    add_req(aff2d_pkg::OP_PASS, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX,
            Q_MAX, Q_MAX, 9'h1ff, Q_MAX, Q_MAX);
    wait_drained();

    // Random phases with varying back-pressure
    run_phase(160, 0, 0);
    run_phase(160, 72, 0);
    // hold the sender until the pipeline is empty
    wait_drained();
    run_phase(165, 0, 72);
    run_phase(165, 38, 38);

    // Drain and let the pipeline settle
    stall_pct = 0;
    wait_drained();
    repeat (20) @(negedge clk);
    if (err_cnt == 0 && exp_points.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/aff2d_pkg.sv
hw/rtl/affine_transform_2d.sv
tb/sv/tb.sv
